### rtl/core/arpc_pkg.sv
// Shared types and constants of the ARP cache engine.
`default_nettype none
package arpc_pkg;

  localparam int IP_W    = 32;
  localparam int MAC_W   = 48;
  localparam int STAMP_W = 32;

  localparam int IN_TDATA_W  = 224;
  localparam int OUT_TDATA_W = 136;

  localparam logic [15:0] ARP_MIN_LEN  = 16'd28;
  localparam logic [15:0] ETH_HW_TYPE  = 16'd1;
  localparam logic [15:0] IPV4_PROTO   = 16'h0800;
  localparam logic [7:0]  ETH_HW_LEN   = 8'd6;
  localparam logic [7:0]  IPV4_LEN     = 8'd4;
  localparam logic [15:0] OPER_REQUEST = 16'd1;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_ARP    = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_UPDATE
  } state_t;

  typedef struct packed {
    logic [IP_W-1:0]    ip;
    logic [MAC_W-1:0]   mac;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic start;
    logic issue;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic last_issue;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

### rtl/core/arpc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module arpc_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 8,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [AW-1:0]        waddr,
  input  wire logic [WIDTH-1:0]     wdata,
  input  wire logic                 re,
  input  wire logic [AW-1:0]        raddr,
  output logic      [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

### rtl/core/arpc_ctrl.sv
// Controller state machine sequencing scan, update and result hand-off.
`default_nettype none
module arpc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire arpc_pkg::sts_t sts,
  output arpc_pkg::cmd_t     cmd
);

  arpc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= arpc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    cmd        = '0;
    unique case (state_r)
      arpc_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.start = 1'b1;
          state_nxt = arpc_pkg::S_SCAN;
        end
      end
      arpc_pkg::S_SCAN: begin
        cmd.issue = 1'b1;
        if (sts.last_issue) begin
          state_nxt = arpc_pkg::S_DRAIN;
        end
      end
      arpc_pkg::S_DRAIN: begin
        state_nxt = arpc_pkg::S_UPDATE;
      end
      arpc_pkg::S_UPDATE: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = arpc_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = arpc_pkg::S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### rtl/core/arpc_dp.sv
// Datapath: entry store, match and victim scan, update and output register.
`default_nettype none
module arpc_dp #(
  parameter int ENTRIES = 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_wr_en,
  input  wire logic [arpc_pkg::IP_W-1:0]          cfg_wr_data,
  input  wire logic [arpc_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  wire logic                               in_tuser,
  input  wire arpc_pkg::cmd_t                     cmd,
  output arpc_pkg::sts_t                          sts,
  input  wire logic                               out_tready,
  output logic                                    out_tvalid,
  output logic [arpc_pkg::OUT_TDATA_W-1:0]        out_tdata
);

  localparam int IDXW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(ENTRIES - 1);

  // unpack input beat
  logic [31:0] f_query_ip, f_sender_ip, f_dest_ip;
  logic [15:0] f_plen, f_hw_type, f_proto_type, f_oper;
  logic [7:0]  f_hw_len, f_proto_len;
  logic [47:0] f_sender_mac;
  logic        f_hdr_ok;

  assign f_query_ip   = in_tdata[31:0];
  assign f_plen       = in_tdata[47:32];
  assign f_hw_type    = in_tdata[63:48];
  assign f_proto_type = in_tdata[79:64];
  assign f_hw_len     = in_tdata[87:80];
  assign f_proto_len  = in_tdata[95:88];
  assign f_oper       = in_tdata[111:96];
  assign f_sender_mac = in_tdata[159:112];
  assign f_sender_ip  = in_tdata[191:160];
  assign f_dest_ip    = in_tdata[223:192];

  assign f_hdr_ok = (f_plen >= arpc_pkg::ARP_MIN_LEN) &&
                    (f_hw_type == arpc_pkg::ETH_HW_TYPE) &&
                    (f_proto_type == arpc_pkg::IPV4_PROTO) &&
                    (f_hw_len == arpc_pkg::ETH_HW_LEN) &&
                    (f_proto_len == arpc_pkg::IPV4_LEN);

  logic [31:0]        own_ip_r;
  logic [31:0]        use_clock_r;
  logic [ENTRIES-1:0] valid_r;

  arpc_pkg::op_t op_r;
  logic [31:0]   key_r;
  logic [47:0]   smac_r;
  logic          hdr_ok_r, to_us_r, req_r;

  logic [IDXW-1:0] rd_idx_r, chk_idx_r;
  logic            chk_vld_r;

  logic            hit_r, free_r, vic_any_r;
  logic [IDXW-1:0] hit_idx_r, vic_idx_r;
  logic [47:0]     hit_mac_r;
  logic [31:0]     vic_stamp_r;

  logic                  out_valid_r;
  logic [arpc_pkg::OUT_TDATA_W-1:0] out_data_r;

  arpc_pkg::entry_t rd_entry, wr_entry;
  logic             ram_we;
  logic [IDXW-1:0]  ram_waddr;
  logic             learn, refresh, found, send_reply, hdr_valid;
  logic [31:0]      stamp_nxt, stamp_diff;
  logic             chk_valid_slot;

  arpc_ram #(
    .WIDTH($bits(arpc_pkg::entry_t)),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(wr_entry),
    .re   (cmd.issue),
    .raddr(rd_idx_r),
    .rdata(rd_entry)
  );

  assign chk_valid_slot = valid_r[chk_idx_r];
  assign stamp_diff     = rd_entry.stamp - vic_stamp_r;
  assign stamp_nxt      = use_clock_r + 32'd1;

  assign hdr_valid  = (op_r == arpc_pkg::OP_ARP) && hdr_ok_r;
  assign found      = (op_r == arpc_pkg::OP_LOOKUP) && hit_r;
  assign refresh    = hit_r && ((op_r == arpc_pkg::OP_LOOKUP) || hdr_ok_r);
  assign learn      = hdr_valid && !hit_r && to_us_r;
  assign send_reply = hdr_valid && req_r && to_us_r;

  assign ram_we    = cmd.commit && (refresh || learn);
  assign ram_waddr = hit_r ? hit_idx_r : vic_idx_r;

  always_comb begin
    wr_entry.ip    = key_r;
    wr_entry.mac   = (op_r == arpc_pkg::OP_LOOKUP) ? hit_mac_r : smac_r;
    wr_entry.stamp = stamp_nxt;
  end

  assign sts.last_issue = (rd_idx_r == LAST_IDX);
  assign sts.out_free   = !out_valid_r || out_tready;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_ip_r    <= '0;
      use_clock_r <= '0;
      valid_r     <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        own_ip_r <= cfg_wr_data;
      end
      chk_vld_r <= cmd.issue;
      if (ram_we) begin
        use_clock_r <= stamp_nxt;
      end
      if (cmd.commit && learn) begin
        valid_r[vic_idx_r] <= 1'b1;
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // capture beat, scan and track match and victim
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r      <= arpc_pkg::op_t'(in_tuser);
      key_r     <= in_tuser ? f_sender_ip : f_query_ip;
      smac_r    <= f_sender_mac;
      hdr_ok_r  <= f_hdr_ok;
      to_us_r   <= (f_dest_ip == own_ip_r);
      req_r     <= (f_oper == arpc_pkg::OPER_REQUEST);
      rd_idx_r  <= '0;
      hit_r     <= 1'b0;
      free_r    <= 1'b0;
      vic_any_r <= 1'b0;
    end else begin
      if (cmd.issue) begin
        rd_idx_r <= rd_idx_r + IDXW'(1);
      end
      if (chk_vld_r) begin
        if (!hit_r && chk_valid_slot && (rd_entry.ip == key_r)) begin
          hit_r     <= 1'b1;
          hit_idx_r <= chk_idx_r;
          hit_mac_r <= rd_entry.mac;
        end
        if (!free_r) begin
          if (!chk_valid_slot) begin
            free_r    <= 1'b1;
            vic_idx_r <= chk_idx_r;
          end else if (!vic_any_r || stamp_diff[31]) begin
            vic_any_r   <= 1'b1;
            vic_idx_r   <= chk_idx_r;
            vic_stamp_r <= rd_entry.stamp;
          end
        end
      end
    end
    chk_idx_r <= rd_idx_r;
    if (cmd.commit) begin
      out_data_r <= {4'd0,
                     send_reply ? key_r : 32'd0,
                     send_reply ? smac_r : 48'd0,
                     send_reply,
                     learn,
                     hdr_valid,
                     found ? hit_mac_r : 48'd0,
                     found};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

### rtl/core/arp_cache_lru_engine.sv
// Top level of the ARP address cache with least-recently-used replacement.
//
// Input stream (in_*): one beat is either a lookup (in_tuser = 0, query_ip)
// or a received ARP header (in_tuser = 1). Output stream (out_*): exactly
// one result beat per input beat, in order. cfg_wr_en/cfg_wr_data write
// our own IPv4 address; write it only while the block is idle.
//
// Each beat scans all ENTRIES slots of the entry RAM, one read per cycle
// through its single read port, for the address match and the victim.
// A drain step and an update step follow the scan; the result is written
// to the output register at the commit, and the next input beat is taken
// only once the block is back in idle.
//
// Reset clears all slot valid bits, the use clock, own address and the
// output valid flag. A held result does not block the next input beat; only
// the following result waits in the update step until out_tready frees the
// output register, and in_tready stays low until then.
`default_nettype none
module arp_cache_lru_engine #(
  parameter int ENTRIES = 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_wr_en,
  input  wire logic [arpc_pkg::IP_W-1:0]          cfg_wr_data,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // query_ip, packet_length, hw_type, proto_type, hw_len, proto_len,
  // arp_oper, sender_mac, sender_ip, dest_ip
  input  wire logic [arpc_pkg::IN_TDATA_W-1:0]    in_tdata,
  // op
  input  wire logic                               in_tuser,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // found, found_mac, header_valid, learned_new, send_reply, reply_mac,
  // reply_ip, 4 zero bits
  output logic [arpc_pkg::OUT_TDATA_W-1:0]        out_tdata
);

  arpc_pkg::cmd_t cmd;
  arpc_pkg::sts_t sts;

  arpc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  arpc_dp #(
    .ENTRIES(ENTRIES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

### rtl/core/arpc_chk.sv
// Port-level checker for the ARP cache engine, bound to the top level.
`default_nettype none
module arpc_chk (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_tvalid,
  input wire logic                               in_tready,
  input wire logic                               out_tvalid,
  input wire logic                               out_tready,
  input wire logic [arpc_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result beat changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again before scan");

  a_kind_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[49]))
    else $error("lookup hit and header result in one beat");

  a_hdr_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[50] || out_tdata[51]) |-> out_tdata[49])
    else $error("learn or reply without valid header");

endmodule

bind arp_cache_lru_engine arpc_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);
`default_nettype wire

### tb/arp_cache_checker.sv
`timescale 1ns / 100ps
// Beat layouts and the result checker with its own copy of the ARP entry table.
package arp_tb_pkg;

  typedef struct packed {
    logic [31:0] dest_ip;
    logic [31:0] sender_ip;
    logic [47:0] sender_mac;
    logic [15:0] arp_oper;
    logic [7:0]  proto_len;
    logic [7:0]  hw_len;
    logic [15:0] proto_type;
    logic [15:0] hw_type;
    logic [15:0] packet_length;
    logic [31:0] query_ip;
  } arp_item_t;

  typedef struct packed {
    logic [3:0]  pad;
    logic [31:0] reply_ip;
    logic [47:0] reply_mac;
    logic        send_reply;
    logic        learned_new;
    logic        header_valid;
    logic [47:0] found_mac;
    logic        found;
  } arp_result_t;

endpackage

module arp_cache_checker #(
  parameter int ENTRIES = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_wr_en,
  input  wire logic [arpc_pkg::IP_W-1:0]       cfg_wr_data,
  input  wire logic                            in_tvalid,
  input  wire logic                            in_tready,
  input  wire logic [arpc_pkg::IN_TDATA_W-1:0] in_tdata,
  input  wire logic                            in_tuser,
  input  wire logic                            out_tvalid,
  input  wire logic                            out_tready,
  input  wire logic [arpc_pkg::OUT_TDATA_W-1:0] out_tdata,
  output int                                   mismatches,
  output int                                   pending
);
  import arpc_pkg::*;
  import arp_tb_pkg::*;

  logic               slot_valid [ENTRIES];
  logic [IP_W-1:0]    slot_ip    [ENTRIES];
  logic [MAC_W-1:0]   slot_mac   [ENTRIES];
  logic [STAMP_W-1:0] slot_stamp [ENTRIES];
  logic [STAMP_W-1:0] use_count;
  logic [IP_W-1:0]    own_addr;
  arp_result_t        expected_q [$];

  function automatic int find_ip(input logic [IP_W-1:0] ip);
    int hit;
    hit = -1;
    for (int i = ENTRIES - 1; i >= 0; i--)
      if (slot_valid[i] && slot_ip[i] == ip) hit = i;
    return hit;
  endfunction

  function automatic arp_result_t predict_result(input logic op_bit, input arp_item_t it);
    arp_result_t r;
    int s, free_idx, old_idx;
    logic to_us;
    logic [STAMP_W-1:0] diff;
    r = '0;
    if (op_t'(op_bit) == OP_LOOKUP) begin
      s = find_ip(it.query_ip);
      if (s >= 0) begin
        r.found = 1'b1;
        r.found_mac = slot_mac[s];
        use_count = use_count + 1'b1;
        slot_stamp[s] = use_count;
      end
    end else if (it.packet_length >= ARP_MIN_LEN && it.hw_type == ETH_HW_TYPE &&
                 it.proto_type == IPV4_PROTO && it.hw_len == ETH_HW_LEN &&
                 it.proto_len == IPV4_LEN) begin
      r.header_valid = 1'b1;
      to_us = (it.dest_ip == own_addr);
      s = find_ip(it.sender_ip);
      if (s < 0 && to_us) begin
        free_idx = -1;
        old_idx = -1;
        for (int i = 0; i < ENTRIES; i++) begin
          if (!slot_valid[i]) begin
            if (free_idx < 0) free_idx = i;
          end else if (old_idx < 0) begin
            old_idx = i;
          end else begin
            diff = slot_stamp[i] - slot_stamp[old_idx];
            if (diff[STAMP_W-1]) old_idx = i;
          end
        end
        s = (free_idx >= 0) ? free_idx : old_idx;
        slot_valid[s] = 1'b1;
        slot_ip[s] = it.sender_ip;
        r.learned_new = 1'b1;
      end
      if (s >= 0) begin
        slot_mac[s] = it.sender_mac;
        use_count = use_count + 1'b1;
        slot_stamp[s] = use_count;
      end
      if (to_us && it.arp_oper == OPER_REQUEST) begin
        r.send_reply = 1'b1;
        r.reply_mac = it.sender_mac;
        r.reply_ip = it.sender_ip;
      end
    end
    return r;
  endfunction

  task automatic note_mismatch(input string what, input logic [MAC_W-1:0] want_v,
                               input logic [MAC_W-1:0] got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: expected %h, got %h", $time, what, want_v, got_v);
  endtask

  always @(posedge clk) begin : watch
    arp_result_t got, want;
    if (!rst_n) begin
      foreach (slot_valid[i]) slot_valid[i] = 1'b0;
      use_count = '0;
      own_addr = '0;
      mismatches = 0;
      expected_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_q.size() == 0) begin
          note_mismatch("result beat with none outstanding", '0, out_tdata[MAC_W-1:0]);
        end else begin
          want = expected_q.pop_front();
          if (got.found !== want.found)
            note_mismatch("found", MAC_W'(want.found), MAC_W'(got.found));
          if (got.found_mac !== want.found_mac)
            note_mismatch("found_mac", want.found_mac, got.found_mac);
          if (got.header_valid !== want.header_valid)
            note_mismatch("header_valid", MAC_W'(want.header_valid),
                          MAC_W'(got.header_valid));
          if (got.learned_new !== want.learned_new)
            note_mismatch("learned_new", MAC_W'(want.learned_new), MAC_W'(got.learned_new));
          if (got.send_reply !== want.send_reply)
            note_mismatch("send_reply", MAC_W'(want.send_reply), MAC_W'(got.send_reply));
          if (got.reply_mac !== want.reply_mac)
            note_mismatch("reply_mac", want.reply_mac, got.reply_mac);
          if (got.reply_ip !== want.reply_ip)
            note_mismatch("reply_ip", MAC_W'(want.reply_ip), MAC_W'(got.reply_ip));
          if (got.pad !== want.pad)
            note_mismatch("padding", MAC_W'(want.pad), MAC_W'(got.pad));
        end
      end
      if (in_tvalid && in_tready) expected_q.push_back(predict_result(in_tuser, in_tdata));
      if (cfg_wr_en) own_addr = cfg_wr_data;
    end
    pending <= expected_q.size();
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// Top of the ARP cache engine testbench: clock, reset, stimulus and verdict.
module testbench;
  import arpc_pkg::*;
  import arp_tb_pkg::*;

  localparam int          ENTRIES         = 8;
  localparam int          PHASE_ITEMS     = 175;
  localparam int          POOL_SIZE       = 12;
  localparam int          HOLD_CYCLES     = 300;
  localparam logic [15:0] OPER_REPLY      = 16'd2;
  localparam logic [31:0] DIRECTED_OWN_IP = 32'hC0A8_0101;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_wr_en;
  logic [IP_W-1:0]        cfg_wr_data;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  int                     mismatches;
  int                     pending;
  logic                   quiet = 1'b0;
  logic                   long_hold = 1'b0;
  logic [IP_W-1:0]        own_ip_now = '0;
  logic [IP_W-1:0]        sender_pool [POOL_SIZE];

  arp_cache_lru_engine #(.ENTRIES(ENTRIES)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  arp_cache_checker #(.ENTRIES(ENTRIES)) cache_check (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .mismatches(mismatches),
    .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic arp_item_t noise_item();
    return arp_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
  endfunction

  function automatic arp_item_t lookup_item(input logic [IP_W-1:0] ip);
    arp_item_t it;
    it = noise_item();
    it.query_ip = ip;
    return it;
  endfunction

  function automatic arp_item_t arp_header(input logic [15:0] oper, input logic [MAC_W-1:0] smac,
                                           input logic [IP_W-1:0] sip,
                                           input logic [IP_W-1:0] tip);
    arp_item_t it;
    it = noise_item();
    it.packet_length = ARP_MIN_LEN;
    it.hw_type = ETH_HW_TYPE;
    it.proto_type = IPV4_PROTO;
    it.hw_len = ETH_HW_LEN;
    it.proto_len = IPV4_LEN;
    it.arp_oper = oper;
    it.sender_mac = smac;
    it.sender_ip = sip;
    it.dest_ip = tip;
    return it;
  endfunction

  // hold the beat until taken; an optional idle burst goes first
  task automatic offer_beat(input op_t op, input arp_item_t it);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= it;
    in_tuser <= op;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic set_own_ip(input logic [IP_W-1:0] ip);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (ENTRIES + 3) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= ip;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    own_ip_now = ip;
  endtask

  initial begin : receiver
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (long_hold) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  initial begin : stimulus
    arp_item_t h;
    op_t op;
    int kind;
    logic [15:0] oper;
    logic [63:0] wide;
    rst_n <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    set_own_ip(DIRECTED_OWN_IP);
    offer_beat(OP_LOOKUP, lookup_item(32'h0));
    offer_beat(OP_LOOKUP, lookup_item(32'hFFFF_FFFF));
    offer_beat(OP_ARP, arp_header(OPER_REQUEST, 48'h0, 32'h0A00_0001, DIRECTED_OWN_IP));
    offer_beat(OP_LOOKUP, lookup_item(32'h0A00_0001));
    offer_beat(OP_ARP, arp_header(OPER_REPLY, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF,
                                  DIRECTED_OWN_IP));
    offer_beat(OP_LOOKUP, lookup_item(32'hFFFF_FFFF));
    offer_beat(OP_ARP, arp_header(OPER_REQUEST, 48'h0A0B_0C0D_0E0F, 32'h0A00_0002,
                                  32'h0A00_0009));
    offer_beat(OP_LOOKUP, lookup_item(32'h0A00_0002));
    offer_beat(OP_ARP, arp_header(OPER_REQUEST, 48'h0123_4567_89AB, 32'h0A00_0001,
                                  32'h0A00_0009));
    offer_beat(OP_LOOKUP, lookup_item(32'h0A00_0001));
    for (int k = 0; k < 10; k++) begin
      h = arp_header(OPER_REQUEST, 48'h0200_0000_0003, 32'h0A00_0003, DIRECTED_OWN_IP);
      case (k)
        0: h.packet_length = ARP_MIN_LEN - 1'b1;
        1: h.packet_length = '0;
        2: h.hw_type = '0;
        3: h.hw_type = '1;
        4: h.proto_type = 16'h0806;
        5: h.hw_len = ETH_HW_LEN - 1'b1;
        6: h.hw_len = '1;
        7: h.proto_len = '0;
        8: h.proto_len = '1;
        default: begin
          h.packet_length = '1;
          h.arp_oper = '0;
        end
      endcase
      offer_beat(OP_ARP, h);
    end
    offer_beat(OP_ARP, arp_header('1, 48'h0200_0000_0004, 32'h0, DIRECTED_OWN_IP));
    offer_beat(OP_LOOKUP, lookup_item(32'h0A00_0003));
    for (int k = 0; k < 5; k++)
      offer_beat(OP_ARP, arp_header(OPER_REQUEST, 48'h0200_0000_0010 + k, 32'h0B00_0000 + k,
                                    DIRECTED_OWN_IP));
    offer_beat(OP_LOOKUP, lookup_item(32'h0A00_0001));

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: set_own_ip(32'hFFFF_FFFF);
        1: set_own_ip(32'h0);
        default: set_own_ip($urandom);
      endcase
      foreach (sender_pool[i]) sender_pool[i] = $urandom;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 1 && n == 40) long_hold = 1'b1;
        if (p == 3 && n == 75) quiet = 1'b1;
        kind = $urandom_range(0, 99);
        wide = {$urandom, $urandom};
        if (kind < 35) begin
          op = OP_LOOKUP;
          h = lookup_item(($urandom_range(0, 4) != 0) ?
                          sender_pool[$urandom_range(0, POOL_SIZE - 1)] : $urandom);
        end else if (kind < 88) begin
          op = OP_ARP;
          case ($urandom_range(0, 3))
            0, 1: oper = OPER_REQUEST;
            2: oper = OPER_REPLY;
            default: oper = 16'($urandom_range(0, 65535));
          endcase
          h = arp_header(oper, wide[MAC_W-1:0],
                         ($urandom_range(0, 9) != 0) ?
                           sender_pool[$urandom_range(0, POOL_SIZE - 1)] : $urandom,
                         ($urandom_range(0, 4) < 3) ? own_ip_now : $urandom);
          h.packet_length = 16'(($urandom_range(0, 1) != 0) ?
                                $urandom_range(ARP_MIN_LEN, 65535) :
                                $urandom_range(ARP_MIN_LEN, 96));
          if ($urandom_range(0, 6) == 0) begin
            case ($urandom_range(0, 4))
              0: h.packet_length = 16'($urandom_range(0, ARP_MIN_LEN - 1));
              1: h.hw_type = h.hw_type ^ 16'($urandom_range(1, 65535));
              2: h.proto_type = h.proto_type ^ 16'($urandom_range(1, 65535));
              3: h.hw_len = h.hw_len ^ 8'($urandom_range(1, 255));
              default: h.proto_len = h.proto_len ^ 8'($urandom_range(1, 255));
            endcase
          end
        end else begin
          op = OP_ARP;
          h = noise_item();
          if ($urandom_range(0, 1) != 0) h.dest_ip = own_ip_now;
        end
        offer_beat(op, h);
      end
    end

    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (ENTRIES + 12) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

### arp_cache_lru_engine.f
rtl/core/arpc_pkg.sv
rtl/core/arpc_ram.sv
rtl/core/arpc_ctrl.sv
rtl/core/arpc_dp.sv
rtl/core/arp_cache_lru_engine.sv
rtl/core/arpc_chk.sv
tb/arp_cache_checker.sv
tb/testbench.sv
